### src/dlc_pkg.sv
package dlc_pkg;

    localparam int NUM_THREADS = 8;
    localparam int NUM_TYPES   = 3;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 8;
    localparam int THR_W       = $clog2(NUM_THREADS);
    localparam int AVAIL_W     = $clog2(NUM_THREADS * 255 + 1) + 1;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_C = 2'd2;

    localparam logic [CNT_W-1:0] TOTAL_A_RESET = 8'd7;
    localparam logic [CNT_W-1:0] TOTAL_B_RESET = 8'd8;
    localparam logic [CNT_W-1:0] TOTAL_C_RESET = 8'd6;

    typedef logic signed [AVAIL_W-1:0] t_avail;

    typedef struct packed {
        logic [IDX_W-1:0] thread_index;
        logic [CNT_W-1:0] held_a;
        logic [CNT_W-1:0] held_b;
        logic [CNT_W-1:0] held_c;
        logic [CNT_W-1:0] want_a;
        logic [CNT_W-1:0] want_b;
        logic [CNT_W-1:0] want_c;
        logic             end_of_round;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] served_thread;
        logic             is_status;
        logic             all_finished;
        logic             final_item;
    } t_out_item;

    typedef struct packed {
        logic             init;
        logic             sub;
        logic             add;
        logic [THR_W-1:0] idx;
    } t_lane_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_SCAN,
        ST_STATUS
    } t_state;

endpackage

### src/dlc_in_if.sv
interface dlc_in_if;
    logic              valid;
    logic              ready;
    dlc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/dlc_out_if.sv
interface dlc_out_if;
    logic               valid;
    logic               ready;
    dlc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/dlc_lane.sv
// One resource type: its held/want columns and its available count.
module dlc_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [dlc_pkg::THR_W-1:0]     i_wr_idx,
    input  logic [dlc_pkg::CNT_W-1:0]     i_held,
    input  logic [dlc_pkg::CNT_W-1:0]     i_want,
    input  logic [dlc_pkg::CNT_W-1:0]     i_total,
    input  dlc_pkg::t_lane_ctl            i_ctl,
    output logic                          o_fit
);

    logic [dlc_pkg::CNT_W-1:0] r_held [dlc_pkg::NUM_THREADS];
    logic [dlc_pkg::CNT_W-1:0] r_want [dlc_pkg::NUM_THREADS];
    dlc_pkg::t_avail           r_avail;
    dlc_pkg::t_avail           n_avail;
    dlc_pkg::t_avail           w_held_rd;
    dlc_pkg::t_avail           w_want_rd;

    assign w_held_rd = dlc_pkg::t_avail'(r_held[i_ctl.idx]);
    assign w_want_rd = dlc_pkg::t_avail'(r_want[i_ctl.idx]);
    assign o_fit     = (w_want_rd <= r_avail);

    always_comb begin
        n_avail = r_avail;
        if (i_ctl.init) begin
            n_avail = dlc_pkg::t_avail'(i_total);
        end else if (i_ctl.sub) begin
            n_avail = r_avail - w_held_rd;
        end else if (i_ctl.add) begin
            n_avail = r_avail + w_held_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail <= '0;
        end else begin
            r_avail <= n_avail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_held[i_wr_idx] <= i_held;
            r_want[i_wr_idx] <= i_want;
        end
    end

endmodule

### src/dlc_ctrl.sv
// Round sequencer: row loads, holdings sum, grant passes, status; merges lane fits.
module dlc_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dlc_in_if.sink                          i_in_ch,
    dlc_out_if.source                       o_out_ch,
    input  logic [dlc_pkg::NUM_TYPES-1:0]   i_fit,
    output dlc_pkg::t_lane_ctl              o_ctl,
    output logic                            o_wr_en,
    output logic [dlc_pkg::THR_W-1:0]       o_wr_idx
);

    dlc_pkg::t_state                   r_state,    n_state;
    logic [dlc_pkg::THR_W-1:0]         r_idx,      n_idx;
    logic [dlc_pkg::THR_W-1:0]         r_pass,     n_pass;
    logic                              r_granted,  n_granted;
    logic [dlc_pkg::NUM_THREADS-1:0]   r_loaded,   n_loaded;
    logic [dlc_pkg::NUM_THREADS-1:0]   r_finished, n_finished;
    logic                              r_out_valid, n_out_valid;
    dlc_pkg::t_out_item                r_out,      n_out;

    logic w_out_free;
    logic w_cand;
    logic w_last;
    logic w_in_range;

    assign o_wr_idx   = dlc_pkg::THR_W'(i_in_ch.data.thread_index);
    assign w_in_range = (int'(i_in_ch.data.thread_index) < dlc_pkg::NUM_THREADS);
    assign w_out_free = !r_out_valid || o_out_ch.ready;
    assign w_cand     = r_loaded[r_idx] && !r_finished[r_idx] && (&i_fit);
    assign w_last     = (r_idx == dlc_pkg::THR_W'(dlc_pkg::NUM_THREADS - 1));

    assign i_in_ch.ready  = (r_state == dlc_pkg::ST_IDLE);
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pass      = r_pass;
        n_granted   = r_granted;
        n_loaded    = r_loaded;
        n_finished  = r_finished;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out       = r_out;
        o_ctl       = '0;
        o_ctl.idx   = r_idx;
        o_wr_en     = 1'b0;
        case (r_state)
            dlc_pkg::ST_IDLE: begin
                if (i_in_ch.valid) begin
                    if (w_in_range) begin
                        o_wr_en            = 1'b1;
                        n_loaded[o_wr_idx] = 1'b1;
                    end
                    if (i_in_ch.data.end_of_round) begin
                        o_ctl.init = 1'b1;
                        n_idx      = '0;
                        n_state    = dlc_pkg::ST_SUM;
                    end
                end
            end
            dlc_pkg::ST_SUM: begin
                o_ctl.sub = r_loaded[r_idx];
                if (w_last) begin
                    n_idx     = '0;
                    n_pass    = '0;
                    n_granted = 1'b0;
                    n_state   = dlc_pkg::ST_SCAN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            dlc_pkg::ST_SCAN: begin
                if (!w_cand || w_out_free) begin
                    if (w_cand) begin
                        o_ctl.add                 = 1'b1;
                        n_finished[r_idx]         = 1'b1;
                        n_granted                 = 1'b1;
                        n_out_valid               = 1'b1;
                        n_out.served_thread       = dlc_pkg::IDX_W'(r_idx);
                        n_out.is_status           = 1'b0;
                        n_out.all_finished        = 1'b0;
                        n_out.final_item          = 1'b0;
                    end
                    if (w_last) begin
                        if (!(r_granted || w_cand) ||
                            r_pass == dlc_pkg::THR_W'(dlc_pkg::NUM_THREADS - 1)) begin
                            n_state = dlc_pkg::ST_STATUS;
                        end else begin
                            n_pass    = r_pass + 1'b1;
                            n_idx     = '0;
                            n_granted = 1'b0;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            dlc_pkg::ST_STATUS: begin
                if (w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.served_thread = '0;
                    n_out.is_status     = 1'b1;
                    n_out.all_finished  = ((r_finished & r_loaded) == r_loaded);
                    n_out.final_item    = 1'b1;
                    n_loaded            = '0;
                    n_finished          = '0;
                    n_state             = dlc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dlc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlc_pkg::ST_IDLE;
            r_idx       <= '0;
            r_pass      <= '0;
            r_granted   <= 1'b0;
            r_loaded    <= '0;
            r_finished  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pass      <= n_pass;
            r_granted   <= n_granted;
            r_loaded    <= n_loaded;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

### src/deadlock_detection_checker_top.sv
// channel   dir  payload      notes
// i_in_ch   in   t_in_item    one thread row per item; end_of_round closes the round
// o_out_ch  out  t_out_item   grants in service order, then one status item
// i_cfg_*   in   total A/B/C  index 0..2, write only while idle
//
// Row items: one per cycle while idle. Closing item: loads the totals, sums holdings,
// then runs grant passes (up to NUM_THREADS passes, one thread check per cycle through
// the three type lanes), then sends the status item.
// Output stalls hold the scan only at a thread that is about to be granted.
// Reset is synchronous, active low; totals return to 7/8/6, row tables keep content.
module deadlock_detection_checker_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dlc_in_if.sink                            i_in_ch,
    dlc_out_if.source                         o_out_ch,
    input  logic                              i_cfg_we,
    input  logic [dlc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dlc_pkg::CNT_W-1:0]         i_cfg_data
);

    logic [dlc_pkg::CNT_W-1:0]       r_total [dlc_pkg::NUM_TYPES];
    logic [dlc_pkg::CNT_W-1:0]       w_held  [dlc_pkg::NUM_TYPES];
    logic [dlc_pkg::CNT_W-1:0]       w_want  [dlc_pkg::NUM_TYPES];
    logic [dlc_pkg::NUM_TYPES-1:0]   w_fit;
    dlc_pkg::t_lane_ctl              w_ctl;
    logic                            w_wr_en;
    logic [dlc_pkg::THR_W-1:0]       w_wr_idx;

    assign w_held[0] = i_in_ch.data.held_a;
    assign w_held[1] = i_in_ch.data.held_b;
    assign w_held[2] = i_in_ch.data.held_c;
    assign w_want[0] = i_in_ch.data.want_a;
    assign w_want[1] = i_in_ch.data.want_b;
    assign w_want[2] = i_in_ch.data.want_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total[0] <= dlc_pkg::TOTAL_A_RESET;
            r_total[1] <= dlc_pkg::TOTAL_B_RESET;
            r_total[2] <= dlc_pkg::TOTAL_C_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dlc_pkg::CFG_TOTAL_A: r_total[0] <= i_cfg_data;
                dlc_pkg::CFG_TOTAL_B: r_total[1] <= i_cfg_data;
                dlc_pkg::CFG_TOTAL_C: r_total[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dlc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .o_out_ch (o_out_ch),
        .i_fit    (w_fit),
        .o_ctl    (w_ctl),
        .o_wr_en  (w_wr_en),
        .o_wr_idx (w_wr_idx)
    );

    for (genvar g = 0; g < dlc_pkg::NUM_TYPES; g++) begin : g_lane
        dlc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (w_wr_en),
            .i_wr_idx (w_wr_idx),
            .i_held   (w_held[g]),
            .i_want   (w_want[g]),
            .i_total  (r_total[g]),
            .i_ctl    (w_ctl),
            .o_fit    (w_fit[g])
        );
    end

    a_close_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready && i_in_ch.data.end_of_round) |=> !i_in_ch.ready)
        else $error("input still ready after round close");

    a_grant_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && !o_out_ch.data.is_status) |->
        (!o_out_ch.data.all_finished && !o_out_ch.data.final_item))
        else $error("grant item carries status flags");

    a_lane_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ctl.init, w_ctl.sub, w_ctl.add}))
        else $error("conflicting lane commands");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (i_in_ch.ready && !w_ctl.sub && !w_ctl.add))
        else $error("row write during check");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_ch.valid)
        else $error("output valid after reset");

endmodule

### tb/tb_deadlock_detection_checker_top.sv
module tb_deadlock_detection_checker_top;

    localparam int TIMEOUT_CYCLES = 500_000;
    localparam int ROW_TARGET     = 320;
    localparam int LONG_HOLD      = 400;
    localparam logic [dlc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    class safety_scoreboard;
        logic [dlc_pkg::CNT_W-1:0]       totals [dlc_pkg::NUM_TYPES];
        logic [dlc_pkg::CNT_W-1:0]       held_cnt [dlc_pkg::NUM_THREADS][dlc_pkg::NUM_TYPES];
        logic [dlc_pkg::CNT_W-1:0]       want_cnt [dlc_pkg::NUM_THREADS][dlc_pkg::NUM_TYPES];
        logic [dlc_pkg::NUM_THREADS-1:0] loaded;
        dlc_pkg::t_out_item              expected_results [$];
        int                              mismatch_count;
        int                              results_seen;

        function new();
            totals[0]      = dlc_pkg::TOTAL_A_RESET;
            totals[1]      = dlc_pkg::TOTAL_B_RESET;
            totals[2]      = dlc_pkg::TOTAL_C_RESET;
            loaded         = '0;
            mismatch_count = 0;
            results_seen   = 0;
        endfunction

        function void set_total(logic [dlc_pkg::CFG_IDX_W-1:0] idx,
                                logic [dlc_pkg::CNT_W-1:0] val);
            case (idx)
                dlc_pkg::CFG_TOTAL_A: totals[0] = val;
                dlc_pkg::CFG_TOTAL_B: totals[1] = val;
                dlc_pkg::CFG_TOTAL_C: totals[2] = val;
                default: ;
            endcase
        endfunction

        // Stores the row; on a closing item runs the safety scan and queues
        // the grants in service order followed by the status item.
        function void note_row(dlc_pkg::t_in_item row);
            dlc_pkg::t_avail                 avail [dlc_pkg::NUM_TYPES];
            logic [dlc_pkg::NUM_THREADS-1:0] done;
            dlc_pkg::t_out_item              res;
            bit                              granted;
            bit                              fits;
            held_cnt[row.thread_index][0] = row.held_a;
            held_cnt[row.thread_index][1] = row.held_b;
            held_cnt[row.thread_index][2] = row.held_c;
            want_cnt[row.thread_index][0] = row.want_a;
            want_cnt[row.thread_index][1] = row.want_b;
            want_cnt[row.thread_index][2] = row.want_c;
            loaded[row.thread_index] = 1'b1;
            if (!row.end_of_round) return;

            for (int k = 0; k < dlc_pkg::NUM_TYPES; k++)
                avail[k] = $signed({1'b0, totals[k]});
            for (int t = 0; t < dlc_pkg::NUM_THREADS; t++) begin
                if (loaded[t]) begin
                    for (int k = 0; k < dlc_pkg::NUM_TYPES; k++)
                        avail[k] = avail[k] - $signed({1'b0, held_cnt[t][k]});
                end
            end

            done = '0;
            for (int sweep = 0; sweep < dlc_pkg::NUM_THREADS; sweep++) begin
                granted = 1'b0;
                for (int t = 0; t < dlc_pkg::NUM_THREADS; t++) begin
                    if (loaded[t] && !done[t]) begin
                        fits = 1'b1;
                        for (int k = 0; k < dlc_pkg::NUM_TYPES; k++) begin
                            if ($signed({1'b0, want_cnt[t][k]}) > avail[k]) fits = 1'b0;
                        end
                        if (fits) begin
                            for (int k = 0; k < dlc_pkg::NUM_TYPES; k++)
                                avail[k] = avail[k] + $signed({1'b0, held_cnt[t][k]});
                            done[t] = 1'b1;
                            granted = 1'b1;
                            res = '0;
                            res.served_thread = dlc_pkg::IDX_W'(t);
                            expected_results.push_back(res);
                        end
                    end
                end
                if (!granted) break;
            end

            res = '0;
            res.is_status    = 1'b1;
            res.all_finished = ((done & loaded) == loaded);
            res.final_item   = 1'b1;
            expected_results.push_back(res);
            loaded = '0;
        endfunction

        function void check_result(dlc_pkg::t_out_item got);
            dlc_pkg::t_out_item exp_res;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: thread %0d status %0b all %0b final %0b",
                             got.served_thread, got.is_status, got.all_finished,
                             got.final_item);
                return;
            end
            exp_res = expected_results.pop_front();
            if (got.served_thread !== exp_res.served_thread ||
                got.is_status     !== exp_res.is_status     ||
                got.all_finished  !== exp_res.all_finished  ||
                got.final_item    !== exp_res.final_item) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"mismatch: exp thread %0d st %0b all %0b fin %0b, ",
                              "got %0d %0b %0b %0b"},
                             exp_res.served_thread, exp_res.is_status,
                             exp_res.all_finished, exp_res.final_item,
                             got.served_thread, got.is_status,
                             got.all_finished, got.final_item);
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [dlc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [dlc_pkg::CNT_W-1:0]     i_cfg_data;

    dlc_in_if  in_ch ();
    dlc_out_if out_ch ();

    safety_scoreboard sb = new();
    int burst_left = 0;
    int items_sent = 0;

    deadlock_detection_checker_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) sb.note_row(in_ch.data);
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    // receiver: segments of always-ready, random and sparse ready, plus one long hold
    initial begin
        int  seg_left;
        int  mode;
        int  tick;
        bit  hold_done;
        seg_left  = 0;
        mode      = 0;
        tick      = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && sb.results_seen >= 30 && in_ch.valid) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                tick++;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    function automatic dlc_pkg::t_in_item build_row(logic [dlc_pkg::IDX_W-1:0] idx,
                                                    int ha, int hb, int hc,
                                                    int wa, int wb, int wc, bit eor);
        dlc_pkg::t_in_item r;
        r.thread_index = idx;
        r.held_a       = dlc_pkg::CNT_W'(ha);
        r.held_b       = dlc_pkg::CNT_W'(hb);
        r.held_c       = dlc_pkg::CNT_W'(hc);
        r.want_a       = dlc_pkg::CNT_W'(wa);
        r.want_b       = dlc_pkg::CNT_W'(wb);
        r.want_c       = dlc_pkg::CNT_W'(wc);
        r.end_of_round = eor;
        return r;
    endfunction

    task automatic send_row(dlc_pkg::t_in_item row);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= row;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic cfg_write(logic [dlc_pkg::CFG_IDX_W-1:0] idx,
                             logic [dlc_pkg::CNT_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_total(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        dlc_pkg::t_in_item row;
        int                val_max;
        int                cap;
        int                rounds;
        int                n;
        int                base;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset totals 7/8/6
        send_row(build_row(3'd0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_row(build_row(3'd7, 255, 255, 255, 255, 255, 255, 1'b1));
        // partial deadlock, thread 2 overwritten
        send_row(build_row(3'd1, 1, 1, 1, 0, 0, 0, 1'b0));
        send_row(build_row(3'd2, 2, 2, 2, 100, 0, 0, 1'b0));
        send_row(build_row(3'd2, 2, 2, 2, 3, 3, 3, 1'b0));
        send_row(build_row(3'd5, 0, 0, 0, 255, 255, 255, 1'b1));
        drain();

        cfg_write(dlc_pkg::CFG_TOTAL_A, 8'd10);
        cfg_write(dlc_pkg::CFG_TOTAL_B, 8'd5);
        cfg_write(dlc_pkg::CFG_TOTAL_C, 8'd7);
        cfg_write(CFG_UNUSED_IDX, 8'hff);
        send_row(build_row(3'd0, 0, 1, 0, 7, 4, 3, 1'b0));
        send_row(build_row(3'd1, 2, 0, 0, 1, 2, 2, 1'b0));
        send_row(build_row(3'd2, 3, 0, 2, 6, 0, 0, 1'b0));
        send_row(build_row(3'd3, 2, 1, 1, 0, 1, 1, 1'b0));
        send_row(build_row(3'd4, 0, 0, 2, 4, 3, 1, 1'b1));
        drain();

        cfg_write(dlc_pkg::CFG_TOTAL_A, 8'd255);
        cfg_write(dlc_pkg::CFG_TOTAL_B, 8'd255);
        cfg_write(dlc_pkg::CFG_TOTAL_C, 8'd255);
        send_row(build_row(3'd3, 255, 255, 255, 0, 0, 0, 1'b0));
        send_row(build_row(3'd4, 0, 0, 0, 255, 255, 255, 1'b1));
        for (int i = 7; i >= 0; i--)
            send_row(build_row(dlc_pkg::IDX_W'(i), 0, 0, 0, 0, 0, 0, i == 0));
        drain();

        cfg_write(dlc_pkg::CFG_TOTAL_A, 8'd0);
        cfg_write(dlc_pkg::CFG_TOTAL_B, 8'd0);
        cfg_write(dlc_pkg::CFG_TOTAL_C, 8'd0);
        send_row(build_row(3'd2, 0, 0, 0, 1, 0, 0, 1'b0));
        send_row(build_row(3'd6, 0, 0, 0, 0, 0, 0, 1'b1));
        drain();

        while (items_sent < ROW_TARGET) begin
            case ($urandom_range(0, 3))
                0: val_max = 3;
                1: val_max = 15;
                2: val_max = 60;
                default: val_max = 255;
            endcase
            cap = (val_max * 8 > 255) ? 255 : val_max * 8;
            if ($urandom_range(0, 4) == 0) begin
                cfg_write(dlc_pkg::CFG_TOTAL_A, $urandom_range(0, 1) ? 8'd255 : 8'd0);
                cfg_write(dlc_pkg::CFG_TOTAL_B, $urandom_range(0, 1) ? 8'd255 : 8'd0);
                cfg_write(dlc_pkg::CFG_TOTAL_C, $urandom_range(0, 1) ? 8'd255 : 8'd0);
            end else begin
                cfg_write(dlc_pkg::CFG_TOTAL_A, dlc_pkg::CNT_W'($urandom_range(0, cap)));
                cfg_write(dlc_pkg::CFG_TOTAL_B, dlc_pkg::CNT_W'($urandom_range(0, cap)));
                cfg_write(dlc_pkg::CFG_TOTAL_C, dlc_pkg::CNT_W'($urandom_range(0, cap)));
            end
            if ($urandom_range(0, 7) == 0)
                cfg_write(CFG_UNUSED_IDX, dlc_pkg::CNT_W'($urandom));

            rounds = $urandom_range(3, 8);
            repeat (rounds) begin
                n    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) :
                                                     $urandom_range(4, 8);
                base = $urandom_range(0, 7);
                for (int i = 0; i < n; i++) begin
                    row.thread_index = ($urandom_range(0, 4) == 0) ?
                                       dlc_pkg::IDX_W'($urandom_range(0, 7)) :
                                       dlc_pkg::IDX_W'(base + i);
                    row.held_a = dlc_pkg::CNT_W'($urandom_range(0, val_max));
                    row.held_b = dlc_pkg::CNT_W'($urandom_range(0, val_max));
                    row.held_c = dlc_pkg::CNT_W'($urandom_range(0, val_max));
                    row.want_a = dlc_pkg::CNT_W'($urandom_range(0,
                                     cap / 2 > val_max ? cap / 2 : val_max));
                    row.want_b = dlc_pkg::CNT_W'($urandom_range(0,
                                     cap / 2 > val_max ? cap / 2 : val_max));
                    row.want_c = dlc_pkg::CNT_W'($urandom_range(0,
                                     cap / 2 > val_max ? cap / 2 : val_max));
                    row.end_of_round = (i == n - 1);
                    send_row(row);
                end
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
